// ===== src/fmm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package fmm_pkg;

    localparam int MAX_M = 8;
    localparam int MAX_N = 8;
    localparam int MAX_K = 256;
    localparam int LANES = 4;

    localparam int ROW_W  = 3;
    localparam int COL_W  = 8;
    localparam int ADDR_W = ROW_W + COL_W;
    localparam int DEPTH  = MAX_M * MAX_K;

    localparam logic [1:0] OP_LOAD_A  = 2'd0;
    localparam logic [1:0] OP_LOAD_BT = 2'd1;
    localparam logic [1:0] OP_COMPUTE = 2'd2;

    localparam logic [1:0] CFG_DIM_M = 2'd0;
    localparam logic [1:0] CFG_DIM_K = 2'd1;
    localparam logic [1:0] CFG_DIM_N = 2'd2;

    localparam logic [31:0] FP_QNAN = 32'h7FC0_0000;
    localparam logic [31:0] FP_ONE  = 32'h3F80_0000;
    localparam logic [31:0] FP_INF  = 32'h7F80_0000;

    typedef struct packed {
        logic [1:0]  op;
        logic [2:0]  row;
        logic [7:0]  col;
        logic [31:0] element_bits;
    } fmm_in_t;

    typedef struct packed {
        logic [2:0]  out_row;
        logic [2:0]  out_col;
        logic [31:0] result_bits;
        logic        last;
    } fmm_out_t;

    typedef struct packed {
        logic              wr_a;
        logic              wr_bt;
        logic [ADDR_W-1:0] wr_addr;
        logic [31:0]       wr_data;
        logic [ADDR_W-1:0] rd_addr_a;
        logic [ADDR_W-1:0] rd_addr_bt;
    } fmm_mem_req_t;

    typedef struct packed {
        logic        start;
        logic [31:0] c;
        logic [31:0] a;
        logic [31:0] b;
    } fmm_fma_req_t;

endpackage
`default_nettype wire

// ===== src/fmm_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
module fmm_store
    import fmm_pkg::*;
(
    input  wire logic         clk,
    input  wire fmm_mem_req_t req,
    output logic [31:0]       rd_a,
    output logic [31:0]       rd_bt
);

    logic [31:0] a_mem [DEPTH];
    logic [31:0] bt_mem [DEPTH];
    logic [31:0] rd_a_reg;
    logic [31:0] rd_bt_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_a)
        begin
            a_mem[req.wr_addr] <= req.wr_data;
        end
        if (req.wr_bt)
        begin
            bt_mem[req.wr_addr] <= req.wr_data;
        end
        rd_a_reg  <= a_mem[req.rd_addr_a];
        rd_bt_reg <= bt_mem[req.rd_addr_bt];
    end

    assign rd_a  = rd_a_reg;
    assign rd_bt = rd_bt_reg;

endmodule
`default_nettype wire

// ===== src/fmm_fma.sv =====
`timescale 1ns / 1ps
`default_nettype none
module fmm_fma
    import fmm_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire fmm_fma_req_t req,
    output logic              done,
    output logic [31:0]       res
);

    localparam logic [2:0] F_IDLE  = 3'd0;
    localparam logic [2:0] F_NORM1 = 3'd1;
    localparam logic [2:0] F_ADD   = 3'd2;
    localparam logic [2:0] F_NORM2 = 3'd3;
    localparam logic [2:0] F_ROUND = 3'd4;
    localparam logic [2:0] F_DONE  = 3'd5;

    logic [2:0]         state_reg, state_next;
    logic [2:0]         cnt_reg, cnt_next;
    logic [63:0]        x_reg, x_next;
    logic [63:0]        y_reg, y_next;
    logic signed [11:0] ex_reg, ex_next;
    logic signed [11:0] ey_reg, ey_next;
    logic               sx_reg, sx_next;
    logic               sy_reg, sy_next;
    logic               czero_reg, czero_next;
    logic [31:0]        res_reg, res_next;

    function automatic logic is_nan(input logic [31:0] v);
        return v[30:0] > 31'h7F80_0000;
    endfunction

    function automatic logic is_inf(input logic [31:0] v);
        return v[30:0] == 31'h7F80_0000;
    endfunction

    function automatic logic is_zero(input logic [31:0] v);
        return v[30:0] == 31'd0;
    endfunction

    function automatic logic [23:0] unp_m(input logic [31:0] v);
        return {(v[30:23] != 8'd0), v[22:0]};
    endfunction

    function automatic logic signed [11:0] unp_e(input logic [31:0] v);
        logic signed [11:0] e;
        if (v[30:23] == 8'd0)
        begin
            e = -12'sd149;
        end
        else
        begin
            e = $signed({4'd0, v[30:23]}) - 12'sd150;
        end
        return e;
    endfunction

    logic               sp, sc;
    logic [6:0]         sh_amt;
    logic [63:0]        bx, by, ya, s;
    logic signed [11:0] bex, bey, dd;
    logic               bsx, bsy, ssign;
    logic [5:0]         sh6;
    logic signed [11:0] e_lsb, e_used, tt, e2, biased;
    logic [6:0]         t7;
    logic [126:0]       ext;
    logic [23:0]        q;
    logic [24:0]        q25;
    logic [23:0]        qf;
    logic               rnd_up;

    assign sp = req.a[31] ^ req.b[31];
    assign sc = req.c[31];
    assign sh_amt = 7'd32 >> cnt_reg;

    always_comb
    begin
        // Alignment and add of the normalized product and addend.
        if (ex_reg < ey_reg)
        begin
            bx = y_reg; bex = ey_reg; bsx = sy_reg;
            by = x_reg; bey = ex_reg; bsy = sx_reg;
        end
        else
        begin
            bx = x_reg; bex = ex_reg; bsx = sx_reg;
            by = y_reg; bey = ey_reg; bsy = sy_reg;
        end
        dd = bex - bey;
        sh6 = dd[5:0];
        if (dd >= 12'sd63)
        begin
            ya = {63'd0, (by != 64'd0)};
        end
        else
        begin
            ya = (by >> sh6) | {63'd0, ((by & ((64'd1 << sh6) - 64'd1)) != 64'd0)};
        end
        if (bsx == bsy)
        begin
            s = bx + ya; ssign = bsx;
        end
        else if (bx >= ya)
        begin
            s = bx - ya; ssign = bsx;
        end
        else
        begin
            s = ya - bx; ssign = bsy;
        end

        // Rounding of the sum, normalized with its leading one at bit 62.
        e_lsb = ex_reg + 12'sd39;
        if (e_lsb < -12'sd149)
        begin
            tt = -12'sd110 - e_lsb;
            e_used = -12'sd149;
        end
        else
        begin
            tt = 12'sd39;
            e_used = e_lsb;
        end
        t7 = (tt > 12'sd127) ? 7'd127 : tt[6:0];
        ext = {x_reg[62:0], 64'd0} >> t7;
        q = ext[87:64];
        rnd_up = ext[63] && ((ext[62:0] != 63'd0) || q[0]);
        q25 = {1'b0, q} + {24'd0, rnd_up};
        if (q25[24])
        begin
            qf = q25[24:1];
            e2 = e_used + 12'sd1;
        end
        else
        begin
            qf = q25[23:0];
            e2 = e_used;
        end
        biased = e2 + 12'sd150;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        ex_next    = ex_reg;
        ey_next    = ey_reg;
        sx_next    = sx_reg;
        sy_next    = sy_reg;
        czero_next = czero_reg;
        res_next   = res_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (req.start)
                begin
                    cnt_next   = 3'd0;
                    x_next     = {40'd0, unp_m(req.a)} * {40'd0, unp_m(req.b)};
                    ex_next    = unp_e(req.a) + unp_e(req.b);
                    y_next     = {40'd0, unp_m(req.c)};
                    ey_next    = unp_e(req.c);
                    sx_next    = sp;
                    sy_next    = sc;
                    czero_next = is_zero(req.c);
                    state_next = F_DONE;
                    if (is_nan(req.a) || is_nan(req.b) || is_nan(req.c))
                    begin
                        res_next = FP_QNAN;
                    end
                    else if (is_inf(req.a) || is_inf(req.b))
                    begin
                        if (is_zero(req.a) || is_zero(req.b))
                        begin
                            res_next = FP_QNAN;
                        end
                        else if (is_inf(req.c) && sc != sp)
                        begin
                            res_next = FP_QNAN;
                        end
                        else
                        begin
                            res_next = {sp, FP_INF[30:0]};
                        end
                    end
                    else if (is_inf(req.c))
                    begin
                        res_next = req.c;
                    end
                    else if (is_zero(req.a) || is_zero(req.b))
                    begin
                        if (!is_zero(req.c) || sp == sc)
                        begin
                            res_next = req.c;
                        end
                        else
                        begin
                            res_next = 32'd0;
                        end
                    end
                    else
                    begin
                        state_next = F_NORM1;
                    end
                end
            end
            F_NORM1:
            begin
                // Binary search for the leading one, moved up to bit 61.
                if ((x_reg >> (7'd62 - sh_amt)) == 64'd0)
                begin
                    x_next  = x_reg << sh_amt;
                    ex_next = ex_reg - $signed({5'd0, sh_amt});
                end
                if ((y_reg >> (7'd62 - sh_amt)) == 64'd0)
                begin
                    y_next  = y_reg << sh_amt;
                    ey_next = ey_reg - $signed({5'd0, sh_amt});
                end
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd5)
                begin
                    state_next = F_ADD;
                end
            end
            F_ADD:
            begin
                cnt_next = 3'd0;
                if (czero_reg)
                begin
                    state_next = F_NORM2;
                end
                else if (s == 64'd0)
                begin
                    res_next   = 32'd0;
                    state_next = F_DONE;
                end
                else
                begin
                    x_next     = s;
                    ex_next    = bex;
                    sx_next    = ssign;
                    state_next = F_NORM2;
                end
            end
            F_NORM2:
            begin
                if ((x_reg >> (7'd63 - sh_amt)) == 64'd0)
                begin
                    x_next  = x_reg << sh_amt;
                    ex_next = ex_reg - $signed({5'd0, sh_amt});
                end
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd5)
                begin
                    state_next = F_ROUND;
                end
            end
            F_ROUND:
            begin
                if (!qf[23])
                begin
                    res_next = {sx_reg, 8'd0, qf[22:0]};
                end
                else if (biased >= 12'sd255)
                begin
                    res_next = {sx_reg, FP_INF[30:0]};
                end
                else
                begin
                    res_next = {sx_reg, biased[7:0], qf[22:0]};
                end
                state_next = F_DONE;
            end
            F_DONE:
            begin
                state_next = F_IDLE;
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cnt_reg   <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        y_reg     <= y_next;
        ex_reg    <= ex_next;
        ey_reg    <= ey_next;
        sx_reg    <= sx_next;
        sy_reg    <= sy_next;
        czero_reg <= czero_next;
        res_reg   <= res_next;
    end

    assign done = (state_reg == F_DONE);
    assign res  = res_reg;

endmodule
`default_nettype wire

// ===== src/fp32_matmul_transposed_b_top.sv =====
// Single precision matrix multiply, A (M x K) times B given as B transposed (N x K).
// Item channel (item_valid, item_stall, item): a beat with op load-A or load-BT
// writes one element into the A or BT memory; loads can stream one beat per cycle
// while no run is going. A compute beat starts a run that emits dim_m*dim_n
// result beats in row-major order, last set on the final one; the item channel is
// stalled until the final result has been placed in the output register.
// Each result walks its K products through one shared fused multiply-add unit,
// one product at a time (memory read, issue, wait in the unit), then three more
// passes through the unit combine the four lane sums before the result is
// emitted. The FMA unit is the bottleneck.
// Configuration (cfg_valid, cfg_ready, cfg_index, cfg_data) is always ready;
// index 0 is dim_m, 1 dim_k, 2 dim_n, others are ignored. Write it while idle.
// Reset (rst_n low, asynchronous) restores dims to 8, 256, 8 and empties the
// output register; matrix memories are not cleared and must be loaded first.
// A result beat waits in the output register while result_stall is high, and the
// run pauses until that register can be refilled.
`timescale 1ns / 1ps
`default_nettype none
module fp32_matmul_transposed_b_top
    import fmm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire fmm_in_t     item,
    output logic             result_valid,
    input  wire logic        result_stall,
    output fmm_out_t         result,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [8:0]  cfg_data
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_ISSUE = 3'd2;
    localparam logic [2:0] ST_WAIT  = 3'd3;
    localparam logic [2:0] ST_SUM   = 3'd4;
    localparam logic [2:0] ST_SUMW  = 3'd5;
    localparam logic [2:0] ST_EMIT  = 3'd6;

    logic [2:0]  state_reg, state_next;
    logic [3:0]  dim_m_reg;
    logic [8:0]  dim_k_reg;
    logic [3:0]  dim_n_reg;
    logic [2:0]  m_last_reg, m_last_next;
    logic [2:0]  n_last_reg, n_last_next;
    logic [7:0]  k_last_reg, k_last_next;
    logic [2:0]  i_reg, i_next;
    logic [2:0]  j_reg, j_next;
    logic [7:0]  k_reg, k_next;
    logic [1:0]  step_reg, step_next;
    logic [31:0] lane_reg [LANES];
    logic [31:0] tmp0_reg, tmp1_reg, sum_reg;
    logic        out_valid_reg, out_valid_next;
    fmm_out_t    out_reg, out_next;

    fmm_mem_req_t mem_req;
    fmm_fma_req_t fma_req;
    logic [31:0]  rd_a, rd_bt;
    logic         fma_done;
    logic [31:0]  fma_res;
    logic         accept, emit_ok, is_last;

    fmm_store u_store (
        .clk   (clk),
        .req   (mem_req),
        .rd_a  (rd_a),
        .rd_bt (rd_bt)
    );

    fmm_fma u_fma (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (fma_req),
        .done  (fma_done),
        .res   (fma_res)
    );

    assign item_stall   = (state_reg != ST_IDLE);
    assign accept       = item_valid && !item_stall;
    assign cfg_ready    = 1'b1;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;
    assign emit_ok      = !out_valid_reg || !result_stall;
    assign is_last      = (i_reg == m_last_reg) && (j_reg == n_last_reg);

    always_comb
    begin
        mem_req.wr_a       = accept && (item.op == OP_LOAD_A);
        mem_req.wr_bt      = accept && (item.op == OP_LOAD_BT);
        mem_req.wr_addr    = {item.row, item.col};
        mem_req.wr_data    = item.element_bits;
        mem_req.rd_addr_a  = {i_reg, k_reg};
        mem_req.rd_addr_bt = {j_reg, k_reg};
    end

    always_comb
    begin
        fma_req.start = (state_reg == ST_ISSUE) || (state_reg == ST_SUM);
        fma_req.c     = lane_reg[k_reg[1:0]];
        fma_req.a     = rd_a;
        fma_req.b     = rd_bt;
        if (state_reg == ST_SUM)
        begin
            fma_req.b = FP_ONE;
            case (step_reg)
                2'd0:
                begin
                    fma_req.c = lane_reg[0];
                    fma_req.a = lane_reg[1];
                end
                2'd1:
                begin
                    fma_req.c = lane_reg[2];
                    fma_req.a = lane_reg[3];
                end
                default:
                begin
                    fma_req.c = tmp0_reg;
                    fma_req.a = tmp1_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        m_last_next    = m_last_reg;
        n_last_next    = n_last_reg;
        k_last_next    = k_last_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && result_stall;
        out_next       = out_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && item.op == OP_COMPUTE)
                begin
                    // Dimensions saturate into their legal ranges at use.
                    if (dim_m_reg == 4'd0)
                    begin
                        m_last_next = 3'd0;
                    end
                    else if (dim_m_reg > 4'(MAX_M))
                    begin
                        m_last_next = 3'(MAX_M - 1);
                    end
                    else
                    begin
                        m_last_next = 3'(dim_m_reg - 4'd1);
                    end
                    if (dim_n_reg == 4'd0)
                    begin
                        n_last_next = 3'd0;
                    end
                    else if (dim_n_reg > 4'(MAX_N))
                    begin
                        n_last_next = 3'(MAX_N - 1);
                    end
                    else
                    begin
                        n_last_next = 3'(dim_n_reg - 4'd1);
                    end
                    if (dim_k_reg == 9'd0)
                    begin
                        k_last_next = 8'd0;
                    end
                    else if (dim_k_reg > 9'(MAX_K))
                    begin
                        k_last_next = 8'(MAX_K - 1);
                    end
                    else
                    begin
                        k_last_next = 8'(dim_k_reg - 9'd1);
                    end
                    i_next     = 3'd0;
                    j_next     = 3'd0;
                    k_next     = 8'd0;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_ISSUE;
            end
            ST_ISSUE:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (fma_done)
                begin
                    if (k_reg == k_last_reg)
                    begin
                        step_next  = 2'd0;
                        state_next = ST_SUM;
                    end
                    else
                    begin
                        k_next     = k_reg + 8'd1;
                        state_next = ST_READ;
                    end
                end
            end
            ST_SUM:
            begin
                state_next = ST_SUMW;
            end
            ST_SUMW:
            begin
                if (fma_done)
                begin
                    if (step_reg == 2'd2)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        step_next  = step_reg + 2'd1;
                        state_next = ST_SUM;
                    end
                end
            end
            ST_EMIT:
            begin
                if (emit_ok)
                begin
                    out_valid_next       = 1'b1;
                    out_next.out_row     = i_reg;
                    out_next.out_col     = j_reg;
                    out_next.result_bits = sum_reg;
                    out_next.last        = is_last;
                    k_next               = 8'd0;
                    if (is_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        if (j_reg == n_last_reg)
                        begin
                            j_next = 3'd0;
                            i_next = i_reg + 3'd1;
                        end
                        else
                        begin
                            j_next = j_reg + 3'd1;
                        end
                        state_next = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            dim_m_reg     <= 4'(MAX_M);
            dim_k_reg     <= 9'(MAX_K);
            dim_n_reg     <= 4'(MAX_N);
            out_valid_reg <= 1'b0;
            m_last_reg    <= 3'd0;
            n_last_reg    <= 3'd0;
            k_last_reg    <= 8'd0;
            i_reg         <= 3'd0;
            j_reg         <= 3'd0;
            k_reg         <= 8'd0;
            step_reg      <= 2'd0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            m_last_reg    <= m_last_next;
            n_last_reg    <= n_last_next;
            k_last_reg    <= k_last_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            step_reg      <= step_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_DIM_M: dim_m_reg <= cfg_data[3:0];
                    CFG_DIM_K: dim_k_reg <= cfg_data;
                    CFG_DIM_N: dim_n_reg <= cfg_data[3:0];
                    default:   dim_m_reg <= dim_m_reg;
                endcase
            end
        end
    end

    // Lane sums start at +0 for every result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                lane_reg[l] <= 32'd0;
            end
        end
        else if ((state_reg == ST_IDLE && state_next == ST_READ) ||
                 (state_reg == ST_EMIT && state_next == ST_READ))
        begin
            for (int l = 0; l < LANES; l++)
            begin
                lane_reg[l] <= 32'd0;
            end
        end
        else if (state_reg == ST_WAIT && fma_done)
        begin
            lane_reg[k_reg[1:0]] <= fma_res;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (state_reg == ST_SUMW && fma_done)
        begin
            case (step_reg)
                2'd0:    tmp0_reg <= fma_res;
                2'd1:    tmp1_reg <= fma_res;
                default: sum_reg  <= fma_res;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== src/fmm_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module fmm_checker
    import fmm_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     item_valid,
    input wire logic     item_stall,
    input wire fmm_in_t  item,
    input wire logic     result_valid,
    input wire logic     result_stall,
    input wire fmm_out_t result
);

    // A waiting result beat holds until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result beat changed while stalled");

    // A compute beat closes the item channel for the run.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && item.op == OP_COMPUTE |=> item_stall)
    else $error("item channel open right after a compute beat");

    // A load or unused-op beat never produces a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && item.op != OP_COMPUTE && !result_valid
        |=> !result_valid)
    else $error("result appeared after a load beat");

    // While a non-final result is pending the run is still going.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last |-> item_stall)
    else $error("item channel open in the middle of a run");

endmodule

bind fp32_matmul_transposed_b_top fmm_checker u_fmm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
`default_nettype wire

// ===== tb/tb_fp32_matmul_transposed_b_top.sv =====
`timescale 1ns / 1ps
module tb_fp32_matmul_transposed_b_top;
    import fmm_pkg::*;

    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int         CYCLE_LIMIT = 800000;
    localparam int         DRAIN_CYCLES = 64;
    localparam int         RANDOM_ITEMS = 370;

    typedef struct {
        fmm_in_t     beat;
        bit          typed;
        logic [31:0] dot;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    fmm_in_t     item;
    logic        result_valid;
    logic        result_stall;
    fmm_out_t    result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [8:0]  cfg_data;

    // Local copy of the block's matrices and dimension registers.
    logic [31:0] a_mem [MAX_M*MAX_K];
    logic [31:0] bt_mem [MAX_N*MAX_K];
    int unsigned dim_m_q, dim_k_q, dim_n_q;

    fmm_out_t    pending_dots [$];
    int          fails;
    int          beats_sent;
    bit          idle_en;
    bit          hold_req;
    longint      cycles;

    fp32_matmul_transposed_b_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic bit fp_is_nan(logic [31:0] v);
        return v[30:0] > 31'h7F80_0000;
    endfunction

    function automatic bit fp_is_inf(logic [31:0] v);
        return v[30:0] == 31'h7F80_0000;
    endfunction

    function automatic bit fp_is_zero(logic [31:0] v);
        return v[30:0] == 31'd0;
    endfunction

    function automatic void fp_split(input logic [31:0] v, output bit [63:0] m,
                                     output int e);
        if (v[30:23] == 8'd0)
        begin
            m = {41'd0, v[22:0]};
            e = -149;
        end
        else
        begin
            m = {40'd0, 1'b1, v[22:0]};
            e = int'(v[30:23]) - 150;
        end
    endfunction

    // c + a*b, single rounding to nearest even, subnormals kept.
    function automatic logic [31:0] fma_rne(logic [31:0] c, logic [31:0] a,
                                            logic [31:0] b);
        bit        sp, sc, sx, sy, sgn, ts;
        bit [63:0] x, y, s, q, ma, mb, tm, rem, half;
        int        ex, ey, e, p, sh, e2, bi, ea, eb, d, te;
        sp = a[31] ^ b[31];
        sc = c[31];
        if (fp_is_nan(a) || fp_is_nan(b) || fp_is_nan(c))
            return FP_QNAN;
        if (fp_is_inf(a) || fp_is_inf(b))
        begin
            if (fp_is_zero(a) || fp_is_zero(b))
                return FP_QNAN;
            if (fp_is_inf(c) && sc != sp)
                return FP_QNAN;
            return {sp, FP_INF[30:0]};
        end
        if (fp_is_inf(c))
            return c;
        if (fp_is_zero(a) || fp_is_zero(b))
        begin
            if (!fp_is_zero(c))
                return c;
            return (sp == sc) ? c : 32'd0;
        end
        fp_split(a, ma, ea);
        fp_split(b, mb, eb);
        x = ma * mb;
        ex = ea + eb;
        while (x[63:61] == 3'd0)
        begin
            x = x << 1;
            ex--;
        end
        sx = sp;
        if (fp_is_zero(c))
        begin
            s = x;
            e = ex;
            sgn = sx;
        end
        else
        begin
            fp_split(c, y, ey);
            while (y[63:61] == 3'd0)
            begin
                y = y << 1;
                ey--;
            end
            sy = sc;
            if (ex < ey)
            begin
                tm = x; te = ex; ts = sx;
                x = y; ex = ey; sx = sy;
                y = tm; ey = te; sy = ts;
            end
            d = ex - ey;
            if (d >= 63)
                y = (y != 0) ? 64'd1 : 64'd0;
            else if (d > 0)
                y = (y >> d) | {63'd0, (y & ((64'd1 << d) - 1)) != 0};
            e = ex;
            if (sx == sy)
            begin
                s = x + y;
                sgn = sx;
            end
            else if (x >= y)
            begin
                s = x - y;
                sgn = sx;
            end
            else
            begin
                s = y - x;
                sgn = sy;
            end
            if (s == 0)
                return 32'd0;
        end
        p = 63;
        while (s[p] == 1'b0)
            p--;
        sh = p - 23;
        if (sh < -149 - e)
            sh = -149 - e;
        if (sh <= 0)
            q = s << (-sh);
        else if (sh >= 64)
            q = 0;
        else
        begin
            rem = s & ((64'd1 << sh) - 1);
            half = 64'd1 << (sh - 1);
            q = s >> sh;
            if (rem > half || (rem == half && q[0]))
                q++;
        end
        e2 = e + sh;
        if (q == (64'd1 << 24))
        begin
            q = q >> 1;
            e2++;
        end
        if (q < (64'd1 << 23))
            return {sgn, 8'd0, q[22:0]};
        bi = e2 + 150;
        if (bi >= 255)
            return {sgn, FP_INF[30:0]};
        return {sgn, bi[7:0], q[22:0]};
    endfunction

    function automatic int unsigned dim_clamp(int unsigned v, int unsigned hi);
        if (v < 1)
            return 1;
        return (v > hi) ? hi : v;
    endfunction

    // Applies one accepted beat to the local matrices, queueing the dot products
    // that a compute beat produces.
    function automatic void predict_matmul(fmm_in_t it);
        int unsigned m, n, kk;
        logic [31:0] lane [LANES];
        logic [31:0] dot;
        fmm_out_t    o;
        case (it.op)
            OP_LOAD_A:  a_mem[it.row*MAX_K + it.col] = it.element_bits;
            OP_LOAD_BT: bt_mem[it.row*MAX_K + it.col] = it.element_bits;
            OP_COMPUTE:
            begin
                m = dim_clamp(dim_m_q, MAX_M);
                n = dim_clamp(dim_n_q, MAX_N);
                kk = dim_clamp(dim_k_q, MAX_K);
                for (int i = 0; i < m; i++)
                begin
                    for (int j = 0; j < n; j++)
                    begin
                        for (int l = 0; l < LANES; l++)
                            lane[l] = 32'd0;
                        for (int k = 0; k < kk; k++)
                            lane[k % LANES] = fma_rne(lane[k % LANES],
                                a_mem[i*MAX_K + k], bt_mem[j*MAX_K + k]);
                        dot = fma_rne(fma_rne(lane[0], lane[1], FP_ONE),
                                      fma_rne(lane[2], lane[3], FP_ONE), FP_ONE);
                        o.out_row = i[2:0];
                        o.out_col = j[2:0];
                        o.result_bits = dot;
                        o.last = (i == m - 1) && (j == n - 1);
                        pending_dots.push_back(o);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic logic [31:0] rand_element();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel <= 5)
            return {1'($urandom), 8'($urandom_range(110, 140)), 23'($urandom)};
        if (sel == 6)
            return {1'($urandom), 31'd0};
        if (sel == 7)
            return {1'($urandom), 8'hFF, ($urandom_range(0, 1) ? 23'd0 : 23'($urandom))};
        if (sel == 8)
            return {1'($urandom), 8'd0, 23'($urandom)};
        return 32'($urandom);
    endfunction

    function automatic fmm_in_t mk_beat(logic [1:0] op, int row, int col,
                                        logic [31:0] bits);
        fmm_in_t it;
        it.op = op;
        it.row = row[2:0];
        it.col = col[7:0];
        it.element_bits = bits;
        return it;
    endfunction

    task automatic send_beat(fmm_in_t it, bit typed = 1'b0, logic [31:0] dot = '0);
        fmm_out_t o;
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        beats_sent++;
        if (typed)
        begin
            o.out_row = 3'd0;
            o.out_col = 3'd0;
            o.result_bits = dot;
            o.last = 1'b1;
            pending_dots.push_back(o);
        end
        else
            predict_matmul(it);
    endtask

    task automatic stop_sending();
        item_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Leaves cfg_valid high so that writes can follow back to back; the caller
    // drops it.
    task automatic write_dim(logic [1:0] idx, int unsigned val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[8:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_DIM_M: dim_m_q = val & 32'hF;
            CFG_DIM_K: dim_k_q = val & 32'h1FF;
            CFG_DIM_N: dim_n_q = val & 32'hF;
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending_dots.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_dims(int unsigned m, int unsigned kk, int unsigned n);
        write_dim(CFG_DIM_M, m);
        write_dim(CFG_DIM_K, kk);
        write_dim(CFG_DIM_N, n);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Loads every element that the next compute reads, with a few stray loads
    // and unused-op beats mixed in, then computes.
    task automatic load_and_compute(int unsigned m, int unsigned kk, int unsigned n);
        int unsigned km, mm, nm;
        km = dim_clamp(kk, MAX_K);
        mm = dim_clamp(m, MAX_M);
        nm = dim_clamp(n, MAX_N);
        for (int r = 0; r < mm; r++)
            for (int c = 0; c < km; c++)
                send_beat(mk_beat(OP_LOAD_A, r, c, rand_element()));
        for (int r = 0; r < nm; r++)
            for (int c = 0; c < km; c++)
            begin
                send_beat(mk_beat(OP_LOAD_BT, r, c, rand_element()));
                if ($urandom_range(0, 19) == 0)
                    send_beat(mk_beat(OP_UNUSED, $urandom_range(0, 7),
                                      $urandom_range(0, 255), 32'($urandom)));
                if ($urandom_range(0, 19) == 0)
                    send_beat(mk_beat(2'($urandom_range(0, 1)), $urandom_range(0, 7),
                                      $urandom_range(0, 255), 32'($urandom)));
            end
        send_beat(mk_beat(OP_COMPUTE, $urandom_range(0, 7), $urandom_range(0, 255),
                          32'($urandom)));
    endtask

    // Result side: checks each beat and drives result_stall.
    initial
    begin
        int stall_left;
        int long_hold;
        fmm_out_t want;
        stall_left = 0;
        long_hold = 0;
        forever
        begin
            @(posedge clk);
            if (result_valid && !result_stall)
            begin
                if (pending_dots.size() == 0)
                begin
                    $error("unexpected result beat row %0d col %0d bits %h",
                           result.out_row, result.out_col, result.result_bits);
                    fails++;
                end
                else
                begin
                    want = pending_dots.pop_front();
                    if (result.out_row !== want.out_row)
                    begin
                        $error("out_row expected %0d actual %0d", want.out_row,
                               result.out_row);
                        fails++;
                    end
                    if (result.out_col !== want.out_col)
                    begin
                        $error("out_col expected %0d actual %0d", want.out_col,
                               result.out_col);
                        fails++;
                    end
                    if (result.result_bits !== want.result_bits)
                    begin
                        $error("result_bits expected %h actual %h", want.result_bits,
                               result.result_bits);
                        fails++;
                    end
                    if (result.last !== want.last)
                    begin
                        $error("last expected %0b actual %0b", want.last, result.last);
                        fails++;
                    end
                end
            end
            if (hold_req)
            begin
                hold_req = 1'b0;
                long_hold = 600;
            end
            if (long_hold > 0)
            begin
                long_hold--;
                result_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_stall <= 1'b1;
            end
            else if (idle_en && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 3);
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin
        dir_row_t dir_tab [$];
        int unsigned m, n, kk;
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        result_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        fails = 0;
        beats_sent = 0;
        idle_en = 1'b1;
        hold_req = 1'b0;
        dim_m_q = 8;
        dim_k_q = 256;
        dim_n_q = 8;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // One by one by one: each compute shows a single product.
        dir_tab = '{
            '{mk_beat(OP_LOAD_A, 0, 0, FP_INF), 0, 0},
            '{mk_beat(OP_LOAD_BT, 0, 0, 32'h0000_0000), 0, 0},
            '{mk_beat(OP_COMPUTE, 0, 0, 32'h0), 1, FP_QNAN},
            '{mk_beat(OP_LOAD_A, 0, 0, 32'h4000_0000), 0, 0},
            '{mk_beat(OP_LOAD_BT, 0, 0, 32'h4040_0000), 0, 0},
            '{mk_beat(OP_COMPUTE, 7, 255, 32'hFFFF_FFFF), 1, 32'h40C0_0000},
            '{mk_beat(OP_LOAD_A, 0, 0, 32'h7F7F_FFFF), 0, 0},
            '{mk_beat(OP_COMPUTE, 0, 0, 32'h0), 1, FP_INF},
            '{mk_beat(OP_LOAD_A, 0, 0, 32'hBF80_0000), 0, 0},
            '{mk_beat(OP_LOAD_BT, 0, 0, 32'h0000_0000), 0, 0},
            '{mk_beat(OP_COMPUTE, 0, 0, 32'h0), 1, 32'h0000_0000},
            '{mk_beat(OP_LOAD_A, 0, 0, 32'h0000_0001), 0, 0},
            '{mk_beat(OP_LOAD_BT, 0, 0, FP_ONE), 0, 0},
            '{mk_beat(OP_COMPUTE, 0, 0, 32'h0), 1, 32'h0000_0001},
            '{mk_beat(OP_LOAD_A, 0, 0, 32'hFF80_0000), 0, 0},
            '{mk_beat(OP_LOAD_BT, 0, 0, 32'h4000_0000), 0, 0},
            '{mk_beat(OP_COMPUTE, 0, 0, 32'h0), 1, 32'hFF80_0000},
            '{mk_beat(OP_LOAD_A, 0, 0, 32'h7FFF_FFFF), 0, 0},
            '{mk_beat(OP_UNUSED, 7, 255, 32'hFFFF_FFFF), 0, 0},
            '{mk_beat(OP_COMPUTE, 0, 0, 32'h0), 1, FP_QNAN},
            '{mk_beat(OP_LOAD_A, 7, 255, 32'hFFFF_FFFF), 0, 0},
            '{mk_beat(OP_LOAD_BT, 7, 255, 32'h0000_0000), 0, 0}
        };
        write_dim(CFG_UNUSED, 9'h1FF);
        set_dims(1, 1, 1);
        foreach (dir_tab[r])
            send_beat(dir_tab[r].beat, dir_tab[r].typed, dir_tab[r].dot);
        wait_drained();

        // Out-of-range dimensions: zero saturates up, large values saturate down.
        set_dims(0, 13, 0);
        load_and_compute(0, 13, 0);
        wait_drained();

        set_dims(15, 0, 15);
        load_and_compute(15, 0, 15);
        // The result side holds off while further loads wait behind the run.
        hold_req = 1'b1;
        for (int r = 0; r < 10; r++)
            send_beat(mk_beat(2'($urandom_range(0, 1)), $urandom_range(0, 7), 0,
                              rand_element()));
        wait_drained();

        while (beats_sent < RANDOM_ITEMS)
        begin
            if (beats_sent > RANDOM_ITEMS - 60)
                idle_en = 1'b0;
            m = $urandom_range(1, 3);
            n = $urandom_range(1, 3);
            kk = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
            if ($urandom_range(0, 9) == 0)
                m = $urandom_range(4, 8);
            set_dims(m, kk, n);
            load_and_compute(m, kk, n);
            if ($urandom_range(0, 3) == 0)
                send_beat(mk_beat(OP_COMPUTE, 0, 0, 32'($urandom)));
            wait_drained();
        end

        stop_sending();
        while (pending_dots.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fails == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
